/* hdl/cct_pkg.sv */
// ----------------------------------------------------------------------------
// Clock calendar tick package
// Shared widths, codes, result layout and calendar helpers.
// ----------------------------------------------------------------------------
package cct_pkg;

    localparam int TICK_COUNT_BITS = 32;

    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int COUNT_W  = 32;
    localparam int SETVAL_W = 16;
    localparam int QUOT_W   = 9;

    localparam int RESULT_W = HOUR_W + MIN_W + SEC_W + DAY_W + MONTH_W + YEAR_W
                              + COUNT_W + 1;
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [YEAR_W-1:0]  YEAR_RESET  = 14'd2000;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_SET   = 1'b1;
    localparam logic FORMAT_24H = 1'b0;
    localparam logic FORMAT_12H = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic                  negative;
        logic [SETVAL_W-2:0]   raw;
        logic [QUOT_W-1:0]     quot;
    } item_t;

    typedef struct packed {
        logic                  set_error;
        logic [COUNT_W-1:0]    tick_count;
        logic [YEAR_W-1:0]     year;
        logic [MONTH_W-1:0]    month;
        logic [DAY_W-1:0]      day;
        logic [SEC_W-1:0]      seconds;
        logic [MIN_W-1:0]      minutes;
        logic [HOUR_W-1:0]     hours;
    } result_t;

    function automatic logic [DAY_W-1:0] month_days(
        input logic [MONTH_W-1:0] month,
        input logic               leap
    );
        logic [DAY_W-1:0] days;
        unique case (month)
            4'd2:                   days = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: days = 5'd30;
            default:                days = 5'd31;
        endcase
        return days;
    endfunction

endpackage

/* hdl/cct_in_stage.sv */
// ----------------------------------------------------------------------------
// Input stage
// Registers an accepted item and splits a set value into its hundreds.
// ----------------------------------------------------------------------------
module cct_in_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [cct_pkg::SETVAL_W-1:0] s_tdata,
    input  logic                        s_tuser,
    input  logic                        advance,
    output logic                        item_valid,
    output cct_pkg::item_t              item
);
    import cct_pkg::*;

    logic                         valid_reg;
    logic                         valid_next;
    item_t                        item_reg;
    item_t                        item_next;
    logic [SETVAL_W-2:0]          raw;
    logic [SETVAL_W+13-2:0]       product;

    assign raw     = s_tdata[SETVAL_W-2:0];
    assign product = raw * RECIP_100;

    always_comb begin
        item_next.mode     = s_tuser;
        item_next.negative = s_tdata[SETVAL_W-1];
        item_next.raw      = raw;
        item_next.quot     = product[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
    end

    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* hdl/cct_core.sv */
// ----------------------------------------------------------------------------
// Time and date core
// Holds the clock and calendar state and works out each item's result.
// ----------------------------------------------------------------------------
module cct_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data,
    input  logic             update,
    input  cct_pkg::item_t   item,
    output cct_pkg::result_t result
);
    import cct_pkg::*;

    logic                        format_reg;
    logic [HOUR_W-1:0]           hour_reg,   hour_next;
    logic [MIN_W-1:0]            minute_reg, minute_next;
    logic [SEC_W-1:0]            second_reg, second_next;
    logic [DAY_W-1:0]            day_reg,    day_next;
    logic [MONTH_W-1:0]          month_reg,  month_next;
    logic [YEAR_W-1:0]           year_reg,   year_next;
    logic [TICK_COUNT_BITS-1:0]  tick_reg,   tick_next;
    logic                        leap_reg,   leap_next;
    logic                        error;

    logic [YEAR_W+12:0]          year_prod;
    logic [7:0]                  year_quot;
    logic [YEAR_W-1:0]           year_rem;
    logic [SETVAL_W-2:0]         set_rem;
    logic [HOUR_W-1:0]           shown;
    logic [TICK_COUNT_BITS+COUNT_W-1:0] tick_ext;
    logic                        sec_wrap, min_wrap, hour_wrap;

    // Leap flag is registered from the year; a year only changes on
    // the first of January, long before the end of February.
    assign year_prod = year_reg * RECIP_100;
    assign year_quot = year_prod[RECIP_SHIFT+7:RECIP_SHIFT];
    assign year_rem  = year_reg - YEAR_W'(year_quot * 14'd100);
    assign leap_next = ((year_reg[1:0] == 2'd0) && (year_rem != '0))
                       || ((year_rem == '0) && (year_quot[1:0] == 2'd0));

    assign set_rem   = item.raw - (SETVAL_W-1)'(item.quot * 15'd100);

    assign sec_wrap  = (second_reg == 6'd59);
    assign min_wrap  = (minute_reg == 6'd59);
    assign hour_wrap = (hour_reg == 5'd23);

    always_comb begin
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        day_next    = day_reg;
        month_next  = month_reg;
        year_next   = year_reg;
        tick_next   = tick_reg;
        error       = 1'b0;
        if (item.mode == MODE_TICK) begin
            tick_next   = tick_reg + 1'b1;
            second_next = sec_wrap ? '0 : second_reg + 1'b1;
            if (sec_wrap) begin
                minute_next = min_wrap ? '0 : minute_reg + 1'b1;
                if (min_wrap) begin
                    hour_next = hour_wrap ? '0 : hour_reg + 1'b1;
                end
            end
            if (sec_wrap && min_wrap && hour_wrap) begin
                if (day_reg >= month_days(month_reg, leap_reg)) begin
                    day_next = 5'd1;
                    if (month_reg >= MONTH_DEC) begin
                        month_next = 4'd1;
                        year_next  = year_reg + 1'b1;
                    end else begin
                        month_next = month_reg + 1'b1;
                    end
                end else begin
                    day_next = day_reg + 1'b1;
                end
            end
        end else if (item.negative) begin
            error = 1'b1;
        end else begin
            hour_next   = (item.quot > QUOT_W'(23)) ? 5'd23 : item.quot[HOUR_W-1:0];
            minute_next = (set_rem > 15'd59) ? 6'd59 : set_rem[MIN_W-1:0];
            second_next = '0;
        end
    end

    always_comb begin
        shown = hour_next;
        if (format_reg == FORMAT_12H) begin
            if (hour_next >= 5'd12) begin
                shown = hour_next - 5'd12;
            end
            if (shown == '0) begin
                shown = 5'd12;
            end
        end
    end

    assign tick_ext = {{COUNT_W{1'b0}}, tick_next};

    always_comb begin
        result.hours      = shown;
        result.minutes    = minute_next;
        result.seconds    = second_next;
        result.day        = day_next;
        result.month      = month_next;
        result.year       = year_next;
        result.tick_count = tick_ext[COUNT_W-1:0];
        result.set_error  = error;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg <= FORMAT_24H;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
            day_reg    <= 5'd1;
            month_reg  <= 4'd1;
            year_reg   <= YEAR_RESET;
            tick_reg   <= '0;
            leap_reg   <= 1'b1;
        end else begin
            leap_reg <= leap_next;
            if (cfg_wr_en) begin
                format_reg <= cfg_wr_data;
            end
            if (update) begin
                hour_reg   <= hour_next;
                minute_reg <= minute_next;
                second_reg <= second_next;
                day_reg    <= day_next;
                month_reg  <= month_next;
                year_reg   <= year_next;
                tick_reg   <= tick_next;
            end
        end
    end

endmodule

/* hdl/clock_calendar_tick.sv */
// ----------------------------------------------------------------------------
// Clock calendar tick
// Real-time clock and calendar driven by tick and set transfers.
// ----------------------------------------------------------------------------
// Each input transfer either advances the clock by one second (tuser low) or
// loads the time of day from a decimal HHMM value in tdata (tuser high);
// every input transfer yields exactly one output transfer with the full time,
// date, tick count and set error flag. The block takes one transfer per clock
// cycle while m_tready does not hold the output; each result passes through
// the input register and then the result register. The time format register
// may be written only while no transfer is in flight.
module clock_calendar_tick (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cct_pkg::SETVAL_W-1:0]  s_tdata,   // set_value
    input  logic                          s_tuser,   // mode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hours, minutes, seconds, day, month, year, tick_count, set_error, pad
    output logic [cct_pkg::M_TDATA_W-1:0] m_tdata
);
    import cct_pkg::*;

    logic    item_valid;
    item_t   item;
    logic    advance;
    result_t result;
    result_t result_reg;
    logic    m_valid_reg;
    logic    m_valid_next;

    assign advance = item_valid && (!m_valid_reg || m_tready);

    cct_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    cct_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .update      (advance),
        .item        (item),
        .result      (result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(result_reg);

endmodule

/* hdl/cct_checker.sv */
// ----------------------------------------------------------------------------
// Clock calendar tick checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module cct_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cct_pkg::M_TDATA_W-1:0] m_tdata
);
    import cct_pkg::*;

    result_t res;
    assign res = m_tdata[RESULT_W-1:0];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> res.hours <= 5'd23 && res.minutes <= 6'd59
                     && res.seconds <= 6'd59)
        else $error("time of day out of range");

    a_date: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> res.day != 5'd0 && res.month != 4'd0 && res.month <= 4'd12)
        else $error("date out of range");

    a_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.set_error |-> res.day != 5'd0)
        else $error("error result carries no valid date");

endmodule

bind clock_calendar_tick cct_checker u_cct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
